/* rtl/pewt_pkg.sv */
// ----------------------------------------------------------------------------
// pewt_pkg
// Shared types and constants for the pps edge window tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package pewt_pkg;

	localparam int unsigned NS_PER_SEC = 1000000000;
	localparam int unsigned NS_PER_US  = 1000;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 17;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_LEVEL    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POLL_INTERVAL_US = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WAIT_MARGIN_US   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_READ_LIMIT       = 2'd3;

	localparam logic        RST_CAPTURE_LEVEL    = 1'b1;
	localparam logic [16:0] RST_POLL_INTERVAL_US = 17'd100;
	localparam logic [16:0] RST_WAIT_MARGIN_US   = 17'd15;
	localparam logic [15:0] RST_READ_LIMIT       = 16'd2000;

	localparam logic MODE_POLL = 1'b0;
	localparam logic MODE_WAIT = 1'b1;

	localparam int unsigned IN_TDATA_W  = 88;
	localparam int unsigned OUT_TDATA_W = 96;
	localparam int unsigned OUT_TUSER_W = 4;

	typedef struct packed {
		logic        capture_level;
		logic [16:0] poll_interval_us;
		logic [16:0] wait_margin_us;
		logic [15:0] read_limit;
	} cfg_t;

	typedef struct packed {
		logic        pin_level;
		logic [15:0] reads_before_capture;
		logic [63:0] stamp_ns;
	} in_item_t;

endpackage

`default_nettype wire

/* rtl/pewt_cfg_regs.sv */
// ----------------------------------------------------------------------------
// pewt_cfg_regs
// Configuration register bank written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module pewt_cfg_regs (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [pewt_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [pewt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output pewt_pkg::cfg_t                         cfg
);
	import pewt_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.capture_level    <= RST_CAPTURE_LEVEL;
			cfg_q.poll_interval_us <= RST_POLL_INTERVAL_US;
			cfg_q.wait_margin_us   <= RST_WAIT_MARGIN_US;
			cfg_q.read_limit       <= RST_READ_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_CAPTURE_LEVEL:    cfg_q.capture_level    <= cfg_wdata[0];
				REG_POLL_INTERVAL_US: cfg_q.poll_interval_us <= cfg_wdata[16:0];
				REG_WAIT_MARGIN_US:   cfg_q.wait_margin_us   <= cfg_wdata[16:0];
				REG_READ_LIMIT:       cfg_q.read_limit       <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* rtl/pewt_in_stage.sv */
// ----------------------------------------------------------------------------
// pewt_in_stage
// Input register: takes one transfer per cycle while the next stage moves.
// ----------------------------------------------------------------------------
`default_nettype none

module pewt_in_stage (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [pewt_pkg::IN_TDATA_W-1:0]    s_tdata,
	input  wire logic                               advance,
	output logic                                    valid_s1,
	output pewt_pkg::in_item_t                      item_s1
);
	import pewt_pkg::*;

	logic     valid_q;
	in_item_t item_q;
	logic     take;

	assign s_tready = !valid_q || advance;
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_tready) begin
			valid_q <= s_tvalid;
		end
	end

	// tdata: pin_level [0], reads_before_capture [16:1], stamp_ns [80:17]
	always_ff @(posedge clk) begin
		if (take) begin
			item_q.pin_level            <= s_tdata[0];
			item_q.reads_before_capture <= s_tdata[16:1];
			item_q.stamp_ns             <= s_tdata[80:17];
		end
	end

	assign valid_s1 = valid_q;
	assign item_s1  = item_q;

endmodule

`default_nettype wire

/* rtl/pewt_step.sv */
// ----------------------------------------------------------------------------
// pewt_step
// Tracker state, next-delay arithmetic and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pewt_step (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire pewt_pkg::cfg_t                      cfg,
	input  wire logic                                valid_s1,
	input  wire pewt_pkg::in_item_t                  item_s1,
	output logic                                     advance,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [pewt_pkg::OUT_TDATA_W-1:0]         m_tdata,
	output logic [pewt_pkg::OUT_TUSER_W-1:0]         m_tuser
);
	import pewt_pkg::*;

	logic        mode_q;
	logic        last_level_q;
	logic [63:0] last_stamp_q;
	logic        first_pending_q;

	logic        valid_s2;
	logic [31:0] delay_s2;
	logic [63:0] ev_stamp_s2;
	logic        ev_s2;
	logic        ev_edge_s2;
	logic        miss_s2;
	logic        mode_s2;

	logic        take;
	logic [26:0] poll_ns;
	logic [17:0] lead_us;
	logic [31:0] arm_delay;
	logic [31:0] first_delay;
	logic [26:0] margin_ns;
	logic [64:0] period_x;
	logic [63:0] period;
	logic [63:0] late_delay;
	logic [31:0] late_clamped;
	logic        hit;

	logic        mode_n;
	logic        last_level_n;
	logic        first_pending_n;
	logic        stamp_we;
	logic [31:0] delay_n;
	logic        ev_n;
	logic        miss_n;

	assign advance = !valid_s2 || m_tready;
	assign take    = valid_s1 && advance;

	assign poll_ns   = 27'(cfg.poll_interval_us) * 27'(NS_PER_US);
	assign lead_us   = 18'(cfg.poll_interval_us) + 18'(cfg.poll_interval_us >> 1);
	// lead stays below one second for every 17-bit interval, so no floor needed
	assign arm_delay = 32'(NS_PER_SEC) - (32'(lead_us) * 32'(NS_PER_US));
	assign first_delay = 32'(NS_PER_SEC)
		- (32'(cfg.poll_interval_us >> 1) * 32'(NS_PER_US));
	assign margin_ns = 27'(cfg.wait_margin_us) * 27'(NS_PER_US);

	// measured period, zero if the stamp went backwards
	assign period_x   = {1'b0, item_s1.stamp_ns} - {1'b0, last_stamp_q};
	assign period     = period_x[64] ? 64'd0 : period_x[63:0];
	assign late_delay = (period > 64'(margin_ns)) ? (period - 64'(margin_ns)) : 64'd0;
	assign late_clamped = (late_delay[63:32] != 32'd0) ? 32'hFFFF_FFFF : late_delay[31:0];

	assign hit = (item_s1.reads_before_capture != 16'd0)
		&& (item_s1.reads_before_capture < cfg.read_limit);

	always_comb begin
		mode_n          = mode_q;
		last_level_n    = last_level_q;
		first_pending_n = first_pending_q;
		stamp_we        = 1'b0;
		delay_n         = 32'(poll_ns);
		ev_n            = 1'b0;
		miss_n          = 1'b0;
		priority if (mode_q == MODE_POLL) begin
			if (item_s1.pin_level != last_level_q) begin
				last_level_n = item_s1.pin_level;
				if (item_s1.pin_level == cfg.capture_level) begin
					delay_n         = arm_delay;
					mode_n          = MODE_WAIT;
					first_pending_n = 1'b1;
				end
			end
		end else if (hit) begin
			delay_n         = first_pending_q ? first_delay : late_clamped;
			stamp_we        = 1'b1;
			first_pending_n = 1'b0;
			ev_n            = 1'b1;
		end else begin
			miss_n = 1'b1;
			mode_n = MODE_POLL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= MODE_POLL;
			last_level_q    <= 1'b0;
			last_stamp_q    <= 64'd0;
			first_pending_q <= 1'b1;
			valid_s2        <= 1'b0;
		end else begin
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (take) begin
				mode_q          <= mode_n;
				last_level_q    <= last_level_n;
				first_pending_q <= first_pending_n;
				if (stamp_we) begin
					last_stamp_q <= item_s1.stamp_ns;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			delay_s2    <= delay_n;
			ev_s2       <= ev_n;
			ev_stamp_s2 <= ev_n ? item_s1.stamp_ns : 64'd0;
			ev_edge_s2  <= ev_n ? cfg.capture_level : 1'b0;
			miss_s2     <= miss_n;
			mode_s2     <= mode_n;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {ev_stamp_s2, delay_s2};
	assign m_tuser  = {mode_s2, miss_s2, ev_edge_s2, ev_s2};

endmodule

`default_nettype wire

/* rtl/pps_edge_window_tracker.sv */
// ----------------------------------------------------------------------------
// pps_edge_window_tracker
// Follows a one-pulse-per-second signal sampled at timer expiries.
// ----------------------------------------------------------------------------
//  channel   direction  content
//  s_axis    in         one timer expiry: level, wait-loop reads, stamp
//  m_axis    out        one result per expiry: next delay and event flags
//  cfg       in         register writes, index 0..3
//
//  A transfer can be taken every cycle while m_axis does not stall; its result
//  passes through the input register and then the result register before it
//  is valid on m_axis.
//  The tracker state is updated as an item moves into the result register.
//  A stall on m_axis holds both registers and drops s_axis_tready once the
//  input register is full. Reset clears tracker state and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_edge_window_tracker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// pin_level, reads_before_capture, stamp_ns, zero fill
	input  wire logic [pewt_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// next_delay_ns, event_stamp_ns
	output logic [pewt_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
	// event_valid, event_edge, missed_pulse, mode_after
	output logic [pewt_pkg::OUT_TUSER_W-1:0]       m_axis_tuser,
	input  wire logic                              cfg_we,
	input  wire logic [pewt_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [pewt_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import pewt_pkg::*;

	cfg_t     cfg;
	logic     advance;
	logic     valid_s1;
	in_item_t item_s1;

	pewt_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	pewt_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.s_tdata  (s_axis_tdata),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	pewt_step u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.advance  (advance),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.m_tdata  (m_axis_tdata),
		.m_tuser  (m_axis_tuser)
	);

endmodule

`default_nettype wire
